// ----- hw/rtl/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the segment allocator
// Request and result records, one heap table entry, the scan accumulator that
// travels along the cell chain, and the update command broadcast to the cells.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int HEAP_BYTES      = 65536;
    localparam int HEADER_BYTES    = 32;
    localparam int ALIGN_BYTES     = 16;
    localparam int MIN_SPLIT_BYTES = 32;
    localparam int MAX_BLOCKS      = 64;

    // Widths sized for the table depth: a cell index and a count of cells.
    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int SZ_W  = 16;

    localparam logic [SZ_W-1:0] HDR        = SZ_W'(HEADER_BYTES);
    localparam logic [SZ_W:0]   SPLIT_MIN  = (SZ_W+1)'(HEADER_BYTES + MIN_SPLIT_BYTES);
    localparam logic [SZ_W-1:0] INIT_SIZE  = SZ_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [17:0]     ALIGN_ADD  = 18'(ALIGN_BYTES - 1);
    localparam logic [17:0]     ALIGN_MASK = ~18'(ALIGN_BYTES - 1);

    localparam logic       OPC_ALLOC = 1'b0;
    localparam logic       OPC_FREE  = 1'b1;
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_IGNORED = 3'd1;
    localparam logic [2:0] STS_NO_FIT  = 3'd2;
    localparam logic [2:0] STS_DOUBLE  = 3'd3;
    localparam logic [2:0] STS_UNKNOWN = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [16:0] request_bytes;
        logic [15:0] release_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] payload_address;
        logic [16:0] free_total;
        logic [16:0] largest_free_bytes;
        logic [6:0]  free_block_count;
    } t_rsp;

    typedef struct packed {
        logic            valid;
        logic            free;
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [SZ_W-1:0]  start;
        logic [SZ_W-1:0]  size;
        logic             efree;
        logic             nfree;
        logic [SZ_W:0]    total;
        logic [SZ_W:0]    largest;
        logic [CNT_W-1:0] count;
    } t_acc;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_SPLIT,
        OP_RELEASE,
        OP_MERGE
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [SZ_W-1:0] want;
        logic [SZ_W-1:0] new_start;
        logic [SZ_W-1:0] new_size;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_STATS,
        ST_OUT
    } t_state;

endpackage

// ----- hw/rtl/fsa_cell.sv -----
// ----------------------------------------------------------------------------
// fsa_cell: one heap table entry with its scan stage
// Holds one block descriptor, extends the scan accumulator from its left
// neighbor by one register stage, and applies broadcast table updates, taking
// data from a neighbor when the table shifts.
// ----------------------------------------------------------------------------
module fsa_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fsa_pkg::t_entry             i_left,
    input  fsa_pkg::t_entry             i_right,
    input  fsa_pkg::t_acc               i_acc,
    input  logic                        i_opcode,
    input  logic [16:0]                 i_want,
    input  logic [15:0]                 i_rel,
    input  logic [1:0]                  i_strategy,
    input  fsa_pkg::t_cmd               i_cmd,
    input  logic [fsa_pkg::IDX_W-1:0]   i_pick,
    output fsa_pkg::t_entry             o_entry,
    output fsa_pkg::t_acc               o_acc
);

    localparam logic [fsa_pkg::IDX_W:0] MY_IDX = (fsa_pkg::IDX_W+1)'(IDX);

    fsa_pkg::t_entry r_e, n_e;
    fsa_pkg::t_acc   r_acc, n_acc;
    logic            take, elig;
    logic [fsa_pkg::IDX_W:0] pick_w, pick_n;

    always_comb begin
        elig = r_e.valid && r_e.free && ({1'b0, r_e.size} >= i_want);
        if (i_opcode == fsa_pkg::OPC_FREE) begin
            take = r_e.valid && (({1'b0, r_e.start} + {1'b0, fsa_pkg::HDR}) == {1'b0, i_rel});
        end else if (i_strategy == fsa_pkg::FIT_FIRST) begin
            take = elig && !i_acc.found;
        end else if (i_strategy == fsa_pkg::FIT_BEST) begin
            take = elig && (!i_acc.found || r_e.size < i_acc.size);
        end else begin
            take = elig && (!i_acc.found || r_e.size > i_acc.size);
        end

        n_acc = i_acc;
        if (take) begin
            n_acc.found = 1'b1;
            n_acc.idx   = fsa_pkg::IDX_W'(IDX);
            n_acc.start = r_e.start;
            n_acc.size  = r_e.size;
            n_acc.efree = r_e.free;
            n_acc.nfree = i_right.free;
        end
        if (r_e.valid && r_e.free) begin
            n_acc.total = i_acc.total + {1'b0, r_e.size};
            n_acc.count = i_acc.count + 1'b1;
            if ({1'b0, r_e.size} > i_acc.largest) begin
                n_acc.largest = {1'b0, r_e.size};
            end
        end
    end

    always_comb begin
        pick_w = {1'b0, i_pick};
        pick_n = pick_w + 1'b1;
        n_e    = r_e;
        unique case (i_cmd.op)
            fsa_pkg::OP_NONE: begin
            end
            fsa_pkg::OP_TAKE: begin
                if (MY_IDX == pick_w) begin
                    n_e.free = 1'b0;
                end
            end
            fsa_pkg::OP_SPLIT: begin
                if (MY_IDX == pick_w) begin
                    n_e.free = 1'b0;
                    n_e.size = i_cmd.want;
                end else if (MY_IDX == pick_n) begin
                    n_e.valid = 1'b1;
                    n_e.free  = 1'b1;
                    n_e.start = i_cmd.new_start;
                    n_e.size  = i_cmd.new_size;
                end else if (MY_IDX > pick_n) begin
                    n_e = i_left;
                end
            end
            fsa_pkg::OP_RELEASE: begin
                if (MY_IDX == pick_w) begin
                    n_e.free = 1'b1;
                end
            end
            fsa_pkg::OP_MERGE: begin
                if (MY_IDX == pick_w) begin
                    n_e.free = 1'b1;
                    n_e.size = r_e.size + fsa_pkg::HDR + i_right.size;
                end else if (MY_IDX > pick_w) begin
                    n_e = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= (IDX == 0);
            r_e.free  <= (IDX == 0);
            r_e.start <= '0;
            r_e.size  <= (IDX == 0) ? fsa_pkg::INIT_SIZE : '0;
        end else begin
            r_e <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_entry = r_e;
    assign o_acc   = r_acc;

endmodule

// ----- hw/rtl/fit_strategy_segment_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fit_strategy_segment_allocator_top: heap allocator over a chain of cells
// Channel table:
//   channel   | ports                      | handshake
//   request   | i_req                      | start high while busy low
//   result    | o_rsp                      | o_done high for one cycle
//   config    | i_cfg_wdata                | i_cfg_we high
// Each request passes the scan accumulator along the cell chain, one register
// stage per cycle, once to choose a block and once more to gather the free
// totals after the table update. busy stays high from acceptance through the
// result cycle. Reset is synchronous and leaves one free block covering the
// whole heap and first fit selected. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module fit_strategy_segment_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fsa_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata,
    output logic          o_done,
    output fsa_pkg::t_rsp o_rsp
);

    localparam int MAX_BLOCKS = fsa_pkg::MAX_BLOCKS;
    localparam int CW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CW-1:0] LAST = CW'(MAX_BLOCKS - 1);

    fsa_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [1:0]      r_strategy;
    logic            r_opcode;
    logic [16:0]     r_want;
    logic            r_zero;
    logic [15:0]     r_rel;
    logic [2:0]      r_status, n_status;
    logic [15:0]     r_addr, n_addr;
    fsa_pkg::t_cmd   cmd;
    logic [17:0]     rounded;
    logic [16:0]     left;

    fsa_pkg::t_entry cell_e [MAX_BLOCKS];
    fsa_pkg::t_acc   cell_a [MAX_BLOCKS];
    fsa_pkg::t_acc   acc_last;

    // The table lives in the cells; the accumulator enters empty at cell zero.
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        fsa_cell #(.IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_left     ((g == 0) ? fsa_pkg::t_entry'('0) : cell_e[(g == 0) ? 0 : g - 1]),
            .i_right    ((g == MAX_BLOCKS - 1) ? fsa_pkg::t_entry'('0)
                                               : cell_e[(g == MAX_BLOCKS - 1) ? g : g + 1]),
            .i_acc      ((g == 0) ? fsa_pkg::t_acc'('0) : cell_a[(g == 0) ? 0 : g - 1]),
            .i_opcode   (r_opcode),
            .i_want     (r_want),
            .i_rel      (r_rel),
            .i_strategy (r_strategy),
            .i_cmd      (cmd),
            .i_pick     (acc_last.idx),
            .o_entry    (cell_e[g]),
            .o_acc      (cell_a[g])
        );
    end

    assign acc_last = cell_a[MAX_BLOCKS-1];

    // Size rounding happens once, when the request is taken.
    assign rounded = ({1'b0, i_req.request_bytes} + fsa_pkg::ALIGN_ADD) & fsa_pkg::ALIGN_MASK;
    assign left    = {1'b0, acc_last.size} - r_want;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_status   = r_status;
        n_addr     = r_addr;
        cmd        = '0;
        cmd.op     = fsa_pkg::OP_NONE;
        unique case (r_state)
            fsa_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = fsa_pkg::ST_SCAN;
                    n_cnt   = '0;
                end
            end
            fsa_pkg::ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = fsa_pkg::ST_APPLY;
                end
            end
            fsa_pkg::ST_APPLY: begin
                // The accumulator now holds the chosen or matching block.
                n_state = fsa_pkg::ST_STATS;
                n_cnt   = '0;
                n_addr  = '0;
                cmd.want      = r_want[15:0];
                cmd.new_start = acc_last.start + fsa_pkg::HDR + r_want[15:0];
                cmd.new_size  = left[15:0] - fsa_pkg::HDR;
                if (r_opcode == fsa_pkg::OPC_ALLOC) begin
                    if (r_zero) begin
                        n_status = fsa_pkg::STS_IGNORED;
                    end else if (!acc_last.found) begin
                        n_status = fsa_pkg::STS_NO_FIT;
                    end else begin
                        n_status = fsa_pkg::STS_OK;
                        n_addr   = acc_last.start + fsa_pkg::HDR;
                        if (left >= fsa_pkg::SPLIT_MIN && !cell_e[MAX_BLOCKS-1].valid) begin
                            cmd.op = fsa_pkg::OP_SPLIT;
                        end else begin
                            cmd.op = fsa_pkg::OP_TAKE;
                        end
                    end
                end else begin
                    if (r_rel == '0) begin
                        n_status = fsa_pkg::STS_IGNORED;
                    end else if (!acc_last.found) begin
                        n_status = fsa_pkg::STS_UNKNOWN;
                    end else if (acc_last.efree) begin
                        n_status = fsa_pkg::STS_DOUBLE;
                    end else begin
                        n_status = fsa_pkg::STS_OK;
                        cmd.op   = acc_last.nfree ? fsa_pkg::OP_MERGE : fsa_pkg::OP_RELEASE;
                    end
                end
            end
            fsa_pkg::ST_STATS: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = fsa_pkg::ST_OUT;
                end
            end
            fsa_pkg::ST_OUT: begin
                n_state = fsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = fsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fsa_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_strategy <= fsa_pkg::FIT_FIRST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_strategy <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_addr   <= n_addr;
        if (r_state == fsa_pkg::ST_IDLE && start) begin
            r_opcode <= i_req.opcode;
            // A rounded size past 17 bits saturates, so no block can fit it.
            r_want   <= rounded[17] ? '1 : rounded[16:0];
            r_zero   <= (i_req.request_bytes == '0);
            r_rel    <= i_req.release_address;
        end
    end

    assign busy   = (r_state != fsa_pkg::ST_IDLE);
    assign o_done = (r_state == fsa_pkg::ST_OUT);

    always_comb begin
        o_rsp.status             = r_status;
        o_rsp.payload_address    = r_addr;
        o_rsp.free_total         = acc_last.total;
        o_rsp.largest_free_bytes = acc_last.largest;
        o_rsp.free_block_count   = acc_last.count[6:0];
    end

`ifndef SYNTH
    // A result is a single-cycle strobe and is always followed by idle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    // Only a granted allocate carries an address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status != fsa_pkg::STS_OK |-> o_rsp.payload_address == '0)
        else $error("address given on a failed request");

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");
`endif

endmodule
